// ===== rtl/sspm_pkg.sv =====
`timescale 1ns / 1ps
package sspm_pkg;

   localparam int SCREEN_W = 128;
   localparam int SCREEN_H = 128;
   localparam int DESIGN_W = 320;
   localparam int DESIGN_H = 200;

   localparam int COL_W      = 10;
   localparam int ROW_W      = 8;
   localparam int COLOUR_W   = 8;
   localparam int ORG_W      = 13;
   localparam int DEST_W     = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [ROW_W-1:0] END_MARK = 8'hff;

   // numerator width of the constant dividers, remainder width, screen position width
   localparam int NUM_W  = 21;
   localparam int REM_W  = 9;
   localparam int POS_W  = 16;
   localparam int KX_W   = 11;
   localparam int SPAN_W = 9;

   localparam logic [NUM_W-1:0] RECIP_W = NUM_W'((longint'(1) << NUM_W) / DESIGN_W);
   localparam logic [NUM_W-1:0] RECIP_H = NUM_W'((longint'(1) << NUM_W) / DESIGN_H);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X     = 3'd0,
      CSR_ORIGIN_Y     = 3'd1,
      CSR_SPRITE_WIDTH = 3'd2,
      CSR_MIRROR       = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic [NUM_W-1:0] quo;
      logic [REM_W-1:0] rem;
   } quorem_type;

   typedef struct packed {
      logic                    mirror;
      logic [COL_W-1:0]        sprite_width;
      logic signed [POS_W-1:0] dx0;
      logic signed [POS_W-1:0] dy0;
      logic [COL_W-1:0]        kmax;
   } cfg_type;

   typedef struct packed {
      logic                ok;
      logic                col_sel;
      logic                row_sel;
      logic [KX_W-1:0]     k;
      logic [SPAN_W-1:0]   ytop_off;
      logic [SPAN_W-1:0]   ybot_off;
      logic [SPAN_W-1:0]   j;
      logic [COLOUR_W-1:0] colour;
   } span_type;

   // floor division by the design width or height: reciprocal estimate, one correction
   function automatic quorem_type div_design(input logic [NUM_W-1:0] num, input logic by_h);
      logic [2*NUM_W-1:0] prod;
      logic [NUM_W-1:0]   recip;
      logic [NUM_W-1:0]   dsr;
      logic [NUM_W-1:0]   quo;
      logic [NUM_W-1:0]   rest;
      quorem_type         res;
      recip = by_h ? RECIP_H : RECIP_W;
      dsr   = by_h ? NUM_W'(DESIGN_H) : NUM_W'(DESIGN_W);
      prod  = (2*NUM_W)'(num) * (2*NUM_W)'(recip);
      quo   = prod[2*NUM_W-1:NUM_W];
      rest  = num - NUM_W'(quo * dsr);
      if (rest >= dsr) begin
         quo  = quo + 1'b1;
         rest = rest - dsr;
      end
      res.quo = quo;
      res.rem = rest[REM_W-1:0];
      return res;
   endfunction

endpackage

// ===== rtl/sspm_csr.sv =====
`timescale 1ns / 1ps
module sspm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sspm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sspm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output sspm_pkg::cfg_type                 cfg
);
   import sspm_pkg::*;

   cfg_type                 cfg_ff;
   cfg_type                 cfg_in;
   logic signed [ORG_W-1:0] org;
   logic [ORG_W-1:0]        org_mag;
   quorem_type              org_qx;
   quorem_type              org_qy;
   quorem_type              wid_q;
   logic [POS_W-1:0]        org_x_mag;
   logic [POS_W-1:0]        org_y_mag;
   logic signed [POS_W-1:0] org_x_scaled;
   logic signed [POS_W-1:0] org_y_scaled;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // origin scaling truncates toward zero: divide the magnitude, restore the sign
   always_comb begin
      org       = signed'(csr_wdata[ORG_W-1:0]);
      org_mag   = org[ORG_W-1] ? ORG_W'(-org) : ORG_W'(org);
      org_qx    = div_design(NUM_W'(org_mag) * NUM_W'(SCREEN_W), 1'b0);
      org_qy    = div_design(NUM_W'(org_mag) * NUM_W'(SCREEN_H), 1'b1);
      org_x_mag = POS_W'(org_qx.quo);
      org_y_mag = POS_W'(org_qy.quo);
      org_x_scaled = org[ORG_W-1] ? signed'(-org_x_mag) : signed'(org_x_mag);
      org_y_scaled = org[ORG_W-1] ? signed'(-org_y_mag) : signed'(org_y_mag);
      wid_q     = div_design(NUM_W'(csr_wdata[COL_W-1:0]) * NUM_W'(SCREEN_W), 1'b0);
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ORIGIN_X: begin
               cfg_in.dx0 = org_x_scaled;
            end
            CSR_ORIGIN_Y: begin
               cfg_in.dy0 = org_y_scaled;
            end
            CSR_SPRITE_WIDTH: begin
               cfg_in.sprite_width = csr_wdata[COL_W-1:0];
               cfg_in.kmax         = COL_W'(wid_q.quo);
            end
            CSR_MIRROR: begin
               cfg_in.mirror = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/sspm_span.sv =====
`timescale 1ns / 1ps
module sspm_span (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sspm_pkg::COL_W-1:0]        req_src_column,
   input  logic [sspm_pkg::ROW_W-1:0]        req_post_top,
   input  logic [sspm_pkg::ROW_W-1:0]        req_post_length,
   input  logic [sspm_pkg::ROW_W-1:0]        req_row_in_post,
   input  logic [sspm_pkg::COLOUR_W-1:0]     req_colour,
   input  sspm_pkg::cfg_type                 cfg,
   input  logic                              mid_ready,
   output logic                              mid_valid,
   output sspm_pkg::span_type                mid
);
   import sspm_pkg::*;

   logic                s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0]    s1_col_ff, s1_col_in;
   logic [ROW_W-1:0]    s1_top_ff, s1_top_in;
   logic [ROW_W-1:0]    s1_len_ff, s1_len_in;
   logic [ROW_W-1:0]    s1_row_ff, s1_row_in;
   logic [COLOUR_W-1:0] s1_colour_ff, s1_colour_in;
   logic                mid_valid_ff, mid_valid_in;
   span_type            mid_ff, mid_in;
   span_type            calc;
   logic                mid_adv;
   logic [COL_W-1:0]    cp;
   quorem_type          qc, qt, qb, qr;

   assign mid_adv   = !mid_valid_ff || mid_ready;
   assign req_stall = s1_valid_ff && !mid_adv;
   assign mid_valid = mid_valid_ff;
   assign mid       = mid_ff;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_col_in    = s1_col_ff;
      s1_top_in    = s1_top_ff;
      s1_len_in    = s1_len_ff;
      s1_row_in    = s1_row_ff;
      s1_colour_in = s1_colour_ff;
      if (!req_stall) begin
         s1_valid_in  = req_valid;
         s1_col_in    = req_src_column;
         s1_top_in    = req_post_top;
         s1_len_in    = req_post_length;
         s1_row_in    = req_row_in_post;
         s1_colour_in = req_colour;
      end
   end

   // column and row selection: ceil quotient picks the destination, remainder tells
   // whether that destination maps back to this source position
   always_comb begin
      cp = cfg.mirror ? (cfg.sprite_width - COL_W'(1) - s1_col_ff) : s1_col_ff;
      qc = div_design(NUM_W'(cp) * NUM_W'(SCREEN_W), 1'b0);
      qt = div_design(NUM_W'(s1_top_ff) * NUM_W'(SCREEN_H), 1'b1);
      qb = div_design(NUM_W'(NUM_W'(s1_top_ff) + NUM_W'(s1_len_ff)) * NUM_W'(SCREEN_H), 1'b1);
      qr = div_design(NUM_W'(s1_row_ff) * NUM_W'(SCREEN_H), 1'b1);

      calc.ok       = (s1_col_ff < cfg.sprite_width) && (s1_top_ff != END_MARK)
                      && (s1_row_ff < s1_len_ff);
      calc.col_sel  = (qc.rem == '0) || (qc.rem > REM_W'(DESIGN_W - SCREEN_W));
      calc.k        = KX_W'(qc.quo) + KX_W'(qc.rem != '0);
      calc.ytop_off = SPAN_W'(qt.quo);
      calc.ybot_off = SPAN_W'(qb.quo);
      calc.row_sel  = (qr.rem == '0) || (qr.rem > REM_W'(DESIGN_H - SCREEN_H));
      calc.j        = SPAN_W'(qr.quo) + SPAN_W'(qr.rem != '0);
      calc.colour   = s1_colour_ff;
   end

   always_comb begin
      mid_valid_in = mid_valid_ff;
      mid_in       = mid_ff;
      if (mid_adv) begin
         mid_valid_in = s1_valid_ff;
         mid_in       = calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         mid_valid_ff <= mid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_col_ff    <= s1_col_in;
      s1_top_ff    <= s1_top_in;
      s1_len_ff    <= s1_len_in;
      s1_row_ff    <= s1_row_in;
      s1_colour_ff <= s1_colour_in;
      mid_ff       <= mid_in;
   end

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !mid_adv |=> s1_valid_ff && $stable(s1_col_ff) && $stable(s1_row_ff))
      else $error("input stage lost a held transaction");

   a_span_order: assert property (@(posedge clock) disable iff (reset)
      mid_valid_ff && mid_ff.ok |-> mid_ff.ybot_off >= mid_ff.ytop_off)
      else $error("post span end above its start");

   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      mid_valid_ff && !mid_ready |=> mid_valid_ff && $stable(mid_ff))
      else $error("middle stage changed while held");

endmodule

// ===== rtl/sspm_place.sv =====
`timescale 1ns / 1ps
module sspm_place (
   input  logic                              clock,
   input  logic                              reset,
   input  sspm_pkg::cfg_type                 cfg,
   input  logic                              mid_valid,
   input  sspm_pkg::span_type                mid,
   output logic                              mid_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sspm_pkg::DEST_W-1:0]       rsp_dest_x,
   output logic [sspm_pkg::DEST_W-1:0]       rsp_dest_y,
   output logic [sspm_pkg::COLOUR_W-1:0]     rsp_dest_colour
);
   import sspm_pkg::*;

   logic                    out_valid_ff, out_valid_in;
   logic [DEST_W-1:0]       dest_x_ff, dest_x_in;
   logic [DEST_W-1:0]       dest_y_ff, dest_y_in;
   logic [COLOUR_W-1:0]     dest_colour_ff, dest_colour_in;
   logic                    out_move;
   logic signed [POS_W-1:0] dx, dy;
   logic                    k_ok, span_ok, x_ok, y_ok, hit;

   assign out_move        = !out_valid_ff || !rsp_stall;
   assign mid_ready       = out_move;
   assign rsp_valid       = out_valid_ff;
   assign rsp_dest_x      = dest_x_ff;
   assign rsp_dest_y      = dest_y_ff;
   assign rsp_dest_colour = dest_colour_ff;

   always_comb begin
      dx      = cfg.dx0 + signed'(POS_W'(mid.k));
      dy      = cfg.dy0 + signed'(POS_W'(mid.ytop_off)) + signed'(POS_W'(mid.j));
      k_ok    = mid.k <= KX_W'(cfg.kmax);
      span_ok = ((SPAN_W+1)'(mid.ytop_off) + (SPAN_W+1)'(mid.j)) < (SPAN_W+1)'(mid.ybot_off);
      x_ok    = (dx >= 0) && (dx < signed'(POS_W'(SCREEN_W)));
      y_ok    = (dy >= 0) && (dy < signed'(POS_W'(SCREEN_H)));
      hit     = mid.ok && mid.col_sel && mid.row_sel && k_ok && span_ok && x_ok && y_ok;
   end

   always_comb begin
      out_valid_in   = out_valid_ff;
      dest_x_in      = dest_x_ff;
      dest_y_in      = dest_y_ff;
      dest_colour_in = dest_colour_ff;
      if (out_move) begin
         out_valid_in   = mid_valid && hit;
         dest_x_in      = dx[DEST_W-1:0];
         dest_y_in      = dy[DEST_W-1:0];
         dest_colour_in = mid.colour;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dest_x_ff      <= dest_x_in;
      dest_y_ff      <= dest_y_in;
      dest_colour_ff <= dest_colour_in;
   end

   a_col_drop: assert property (@(posedge clock) disable iff (reset)
      mid_valid && mid_ready && !mid.col_sel |=> !out_valid_ff)
      else $error("unselected column produced a write");

   a_hit_kept: assert property (@(posedge clock) disable iff (reset)
      mid_valid && mid_ready && hit |=> out_valid_ff)
      else $error("selected pixel lost");

endmodule

// ===== rtl/scaled_sprite_pixel_mapper_unit.sv =====
`timescale 1ns / 1ps
// channel  direction  handshake          payload
// req      in         valid / stall      src_column, post_top, post_length, row_in_post, colour
// rsp      out        valid / stall      dest_x, dest_y, dest_colour
// csr      in         valid / ready      index, wdata
//
// One transaction per cycle sustained while rsp_stall is low; a result passes through the input
// register, span register and result register.
// Transactions that select no screen position produce no rsp transaction.
// Synchronous active-high reset clears all valids and config registers to zero.
// rsp_stall holds the result register; stall ripples back stage by stage to req_stall.
// csr is always ready; origin and width scaling are folded in at the write.
module scaled_sprite_pixel_mapper_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sspm_pkg::COL_W-1:0]        req_src_column,
   input  logic [sspm_pkg::ROW_W-1:0]        req_post_top,
   input  logic [sspm_pkg::ROW_W-1:0]        req_post_length,
   input  logic [sspm_pkg::ROW_W-1:0]        req_row_in_post,
   input  logic [sspm_pkg::COLOUR_W-1:0]     req_colour,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sspm_pkg::DEST_W-1:0]       rsp_dest_x,
   output logic [sspm_pkg::DEST_W-1:0]       rsp_dest_y,
   output logic [sspm_pkg::COLOUR_W-1:0]     rsp_dest_colour,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sspm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sspm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sspm_pkg::*;

   cfg_type  cfg;
   span_type mid;
   logic     mid_valid;
   logic     mid_ready;

   sspm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sspm_span u_span (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_src_column  (req_src_column),
      .req_post_top    (req_post_top),
      .req_post_length (req_post_length),
      .req_row_in_post (req_row_in_post),
      .req_colour      (req_colour),
      .cfg             (cfg),
      .mid_ready       (mid_ready),
      .mid_valid       (mid_valid),
      .mid             (mid)
   );

   sspm_place u_place (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .mid_valid       (mid_valid),
      .mid             (mid),
      .mid_ready       (mid_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_dest_x      (rsp_dest_x),
      .rsp_dest_y      (rsp_dest_y),
      .rsp_dest_colour (rsp_dest_colour)
   );

endmodule
